FILE: hdl/hem_pkg.sv
// ----------------------------------------------------------------------------
// hem_pkg
// Types, constants and command structs shared by the histogram equalization
// map controller, datapath and top level.
// ----------------------------------------------------------------------------
package hem_pkg;

	localparam int BIN_COUNT  = 256;
	localparam int BIN_BITS   = 8;
	localparam int COUNT_BITS = 25;
	localparam int DIM_BITS   = 13;
	localparam int PIX_BITS   = 2 * DIM_BITS;
	// numerator (count * 255) width
	localparam int NUM_BITS   = COUNT_BITS + 8;
	localparam int QUO_BITS   = NUM_BITS;
	localparam int QCNT_BITS  = 6;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [DIM_BITS-1:0] COLS_RESET = 13'd640;
	localparam logic [DIM_BITS-1:0] ROWS_RESET = 13'd480;

	// Q16 color coefficients
	localparam logic signed [24:0] K_YR = 25'sd19595;
	localparam logic signed [24:0] K_YG = 25'sd38470;
	localparam logic signed [24:0] K_YB = 25'sd7471;
	localparam logic signed [24:0] K_UR = 25'sd11058;
	localparam logic signed [24:0] K_UG = 25'sd21710;
	localparam logic signed [24:0] K_HALF = 25'sd32768;
	localparam logic signed [24:0] K_VG = 25'sd27439;
	localparam logic signed [24:0] K_VB = 25'sd5329;
	localparam logic signed [24:0] K_OFS = 25'sd8388608;

	localparam logic [0:0] REG_COLS = 1'b0;
	localparam logic [0:0] REG_ROWS = 1'b1;

	// bin read address select
	localparam logic [1:0] RD_LUMA  = 2'd0;
	localparam logic [1:0] RD_LEVEL = 2'd1;
	localparam logic [1:0] RD_SWEEP = 2'd2;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_PIXEL  = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_LOOKUP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOTDONE = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] chan_r;
		logic [7:0] chan_g;
		logic [7:0] chan_b;
		logic [7:0] level;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] luma;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic [7:0] mapped_level;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [15:0] data;
	} cfg_item_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_PIX_MUL,
		S_PIX_SUM,
		S_PIX_RD,
		S_PIX_WR,
		S_FIN_RD,
		S_FIN_ACC,
		S_LK_RD,
		S_LK_MUL,
		S_LK_DIV,
		S_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;      // latch input item
		logic       clear_bin;    // write zero at sweep address
		logic       pix_mul;      // register products
		logic       pix_sum;      // register YUV
		logic       bin_rd;       // read bin at luma / level / sweep
		logic [1:0] rd_sel;       // RD_LUMA, RD_LEVEL, RD_SWEEP
		logic       bin_inc_wr;   // write incremented bin
		logic       fin_acc;      // accumulate and write sweep entry
		logic       sweep_clr;    // reset sweep address
		logic       sweep_step;   // advance sweep address
		logic       lk_mul;       // form numerator and divisor
		logic       div_step;     // one restoring division step
		logic       set_ready;
		logic       clr_ready;
		logic       load_out;     // load result register
	} hem_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_last;
		logic div_last;
		logic ready_flag;
		logic div_bad;
		logic out_busy;
	} hem_sts_t;

endpackage

FILE: hdl/hem_ctrl.sv
// ----------------------------------------------------------------------------
// hem_ctrl
// Sequencer: steps each transaction through the datapath.
// ----------------------------------------------------------------------------
module hem_ctrl import hem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  action_t  in_action,
	output logic     in_ready,
	input  hem_sts_t sts,
	output hem_cmd_t cmd
);

	state_t state_q, state_d;
	action_t act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			act_q   <= ACT_START;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) act_q <= in_action;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			// zero every bin once after reset
			S_INIT: begin
				cmd.clear_bin  = 1'b1;
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture   = 1'b1;
					cmd.sweep_clr = 1'b1;
					case (in_action)
						ACT_START:  state_d = S_CLEAR;
						ACT_PIXEL:  state_d = S_PIX_MUL;
						ACT_FINISH: state_d = S_FIN_RD;
						ACT_LOOKUP: state_d = S_LK_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clear_bin  = 1'b1;
				cmd.sweep_step = 1'b1;
				cmd.clr_ready  = 1'b1;
				if (sts.sweep_last) state_d = S_RESULT;
			end
			S_PIX_MUL: begin
				cmd.pix_mul = 1'b1;
				state_d     = S_PIX_SUM;
			end
			S_PIX_SUM: begin
				cmd.pix_sum = 1'b1;
				state_d     = S_PIX_RD;
			end
			S_PIX_RD: begin
				cmd.bin_rd = 1'b1;
				cmd.rd_sel = RD_LUMA;
				state_d    = S_PIX_WR;
			end
			S_PIX_WR: begin
				cmd.bin_inc_wr = 1'b1;
				state_d        = S_RESULT;
			end
			S_FIN_RD: begin
				if (sts.ready_flag) begin
					state_d = S_RESULT;
				end else begin
					cmd.bin_rd = 1'b1;
					cmd.rd_sel = RD_SWEEP;
					state_d    = S_FIN_ACC;
				end
			end
			S_FIN_ACC: begin
				cmd.fin_acc    = 1'b1;
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					cmd.set_ready = 1'b1;
					state_d       = S_RESULT;
				end else begin
					state_d = S_FIN_RD;
				end
			end
			S_LK_RD: begin
				cmd.bin_rd = 1'b1;
				cmd.rd_sel = RD_LEVEL;
				state_d    = S_LK_MUL;
			end
			S_LK_MUL: begin
				cmd.lk_mul = 1'b1;
				if (!sts.ready_flag || sts.div_bad) state_d = S_RESULT;
				else state_d = S_LK_DIV;
			end
			S_LK_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// a result is loaded only for the transaction just taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> state_q == S_RESULT)
		else $error("result load outside result state");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("second transaction accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> act_q == ACT_LOOKUP)
		else $error("divider stepping outside lookup");

endmodule

FILE: hdl/hem_dp.sv
// ----------------------------------------------------------------------------
// hem_dp
// Datapath: color conversion, bin memory, prefix sweep, serial divider,
// output register.
// ----------------------------------------------------------------------------
module hem_dp import hem_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  in_item_t      in_item,
	input  logic          cfg_we,
	input  cfg_item_t     cfg_item,
	input  hem_cmd_t      cmd,
	output hem_sts_t      sts,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_item
);

	logic [DIM_BITS-1:0] cols_q, rows_q;
	in_item_t item_q;
	logic ready_q;
	logic [COUNT_BITS-1:0] first_q, run_q, rd_q;
	logic [BIN_BITS-1:0] sweep_q;
	logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];

	logic signed [24:0] p_yr_s1, p_yg_s1, p_yb_s1, p_ur_s1, p_ug_s1, p_ub_s1;
	logic signed [24:0] p_vr_s1, p_vg_s1, p_vb_s1;
	logic [7:0] y_s2, u_s2, v_s2;

	logic [QUO_BITS-1:0] quo_q;
	logic [PIX_BITS:0] rem_q;
	logic [PIX_BITS-1:0] den_q;
	logic [QCNT_BITS-1:0] dcnt_q;
	logic bad_q;
	logic out_valid_q;
	out_item_t out_q, out_d;

	function automatic logic [7:0] clamp_q16(input logic signed [24:0] acc);
		logic [7:0] r;
		if (acc < 0) r = 8'd0;
		else if (acc[24:16] > 9'd255) r = 8'd255;
		else r = acc[23:16];
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_we && !cfg_item.index[1]) begin
			if (cfg_item.index[0] == REG_COLS) cols_q <= cfg_item.data[DIM_BITS-1:0];
			else rows_q <= cfg_item.data[DIM_BITS-1:0];
		end
	end

	// input capture and color conversion
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.pix_mul) begin
			p_yr_s1 <= K_YR * $signed({17'd0, item_q.chan_r});
			p_yg_s1 <= K_YG * $signed({17'd0, item_q.chan_g});
			p_yb_s1 <= K_YB * $signed({17'd0, item_q.chan_b});
			p_ur_s1 <= K_UR * $signed({17'd0, item_q.chan_r});
			p_ug_s1 <= K_UG * $signed({17'd0, item_q.chan_g});
			p_ub_s1 <= K_HALF * $signed({17'd0, item_q.chan_b});
			p_vr_s1 <= K_HALF * $signed({17'd0, item_q.chan_r});
			p_vg_s1 <= K_VG * $signed({17'd0, item_q.chan_g});
			p_vb_s1 <= K_VB * $signed({17'd0, item_q.chan_b});
		end
		if (cmd.pix_sum) begin
			y_s2 <= clamp_q16(p_yr_s1 + p_yg_s1 + p_yb_s1);
			u_s2 <= clamp_q16(K_OFS - p_ur_s1 - p_ug_s1 + p_ub_s1);
			v_s2 <= clamp_q16(K_OFS + p_vr_s1 - p_vg_s1 - p_vb_s1);
		end
	end

	// bin memory: one write, one registered read
	logic [BIN_BITS-1:0] rd_addr, wr_addr;
	logic [COUNT_BITS-1:0] wr_data, sum_sat;
	logic [COUNT_BITS:0] sum_w;
	logic wr_en;

	always_comb begin
		case (cmd.rd_sel)
			RD_LUMA:  rd_addr = y_s2;
			RD_LEVEL: rd_addr = item_q.level;
			default:  rd_addr = sweep_q;
		endcase
		sum_w   = {1'b0, rd_q} + {1'b0, run_q};
		sum_sat = sum_w[COUNT_BITS] ? CNT_MAX : sum_w[COUNT_BITS-1:0];
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '0;
		if (cmd.clear_bin) begin
			wr_en = 1'b1;
		end else if (cmd.bin_inc_wr) begin
			wr_en   = !ready_q && rd_q != CNT_MAX;
			wr_addr = y_s2;
			wr_data = rd_q + 1'b1;
		end else if (cmd.fin_acc) begin
			wr_en   = 1'b1;
			wr_data = (sweep_q == '0) ? rd_q : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) bin_mem[wr_addr] <= wr_data;
		if (cmd.bin_rd) rd_q <= bin_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			first_q <= '0;
			sweep_q <= '0;
			run_q   <= '0;
		end else begin
			if (cmd.clr_ready) begin
				ready_q <= 1'b0;
				first_q <= '0;
			end else if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.sweep_clr) sweep_q <= '0;
			else if (cmd.sweep_step) sweep_q <= sweep_q + 1'b1;
			if (cmd.fin_acc) begin
				if (sweep_q == '0) begin
					first_q <= rd_q;
					run_q   <= rd_q;
				end else begin
					run_q <= sum_sat;
				end
			end
		end
	end

	// lookup: numerator*255 and divisor, then restoring division bit-serially
	logic [PIX_BITS-1:0] pix_w;
	logic [PIX_BITS:0] trial_w;
	logic [NUM_BITS-1:0] num_w;
	assign pix_w   = cols_q * rows_q;
	assign num_w   = ({8'd0, rd_q - first_q} << 8) - {8'd0, rd_q - first_q};
	assign trial_w = {rem_q[PIX_BITS-1:0], quo_q[QUO_BITS-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			bad_q  <= 1'b0;
		end else begin
			if (cmd.lk_mul) begin
				bad_q  <= pix_w <= PIX_BITS'(1);
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lk_mul) begin
			quo_q <= num_w;
			rem_q <= '0;
			den_q <= pix_w - 1'b1;
		end else if (cmd.div_step) begin
			if (!trial_w[PIX_BITS]) begin
				rem_q <= trial_w;
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[PIX_BITS-1:0], quo_q[QUO_BITS-1]};
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_d      = '0;
		out_d.kind = item_q.action;
		case (action_t'(item_q.action))
			ACT_PIXEL: begin
				out_d.luma     = y_s2;
				out_d.chroma_u = u_s2;
				out_d.chroma_v = v_s2;
			end
			ACT_LOOKUP: begin
				if (!ready_q) begin
					out_d.status = ST_NOTDONE;
				end else if (bad_q) begin
					out_d.status = ST_DIVZERO;
				end else begin
					out_d.mapped_level = (quo_q > QUO_BITS'(255)) ? 8'd255 : quo_q[7:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) out_q <= out_d;
	end

	assign out_valid      = out_valid_q;
	assign out_item       = out_q;
	assign sts.sweep_last = sweep_q == '1;
	assign sts.div_last   = dcnt_q == QCNT_BITS'(QUO_BITS - 1);
	assign sts.ready_flag = ready_q;
	assign sts.div_bad    = pix_w <= PIX_BITS'(1);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_ready |=> ready_q)
		else $error("ready flag not set by finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped under stall");

endmodule

FILE: hdl/histogram_equalization_map_core.sv
// ----------------------------------------------------------------------------
// histogram_equalization_map_core
// 8-bit luma histogram equalization map with RGB to YUV conversion.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one transaction per
//   item: start clears the 256-bin histogram, pixel converts RGB to YUV and
//   counts Y, finish turns the bins into a cumulative sum, lookup returns
//   the equalized level. Every item gives exactly one out transaction
//   (out_valid/out_ready/out_data).
//   cfg channel writes image_cols (index 0) and image_rows (index 1); it
//   is always ready; use it only while the block is idle (not enforced).
// Sequencing (one item at a time, through the bin memory and divider):
//   pixel converts, reads and rewrites its Y bin; start clears every bin;
//   finish reads then accumulates each bin (straight to the result if
//   already finished); lookup reads the bin, forms numerator and divisor,
//   then divides bit-serially (not on error); items are taken in idle.
// Reset: configuration returns to 640 x 480, the finished flag clears, and
//   a pass over all 256 bins zeroes them; in_ready stays low until it ends.
// Stall: a held result waits in the output register; the sequencer
//   parks until it drains, so nothing is lost.
// ----------------------------------------------------------------------------
module histogram_equalization_map_core import hem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_item_t cfg_data
);

	hem_cmd_t cmd;
	hem_sts_t sts;

	assign cfg_ready = 1'b1;

	hem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_action(action_t'(in_data.action)),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hem_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_data),
		.cfg_we   (cfg_valid),
		.cfg_item (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_data)
	);

endmodule
